/* hdl/ssns_pkg.sv */
// Shared types, codes and the segment glyph table for the seven-segment scanner.
// No dependencies; imported by ssns_bcd and seven_segment_number_scanner_unit.
package ssns_pkg;

   // display mode codes
   localparam logic [1:0] MODE_DEC    = 2'd0;
   localparam logic [1:0] MODE_HEX    = 2'd1;
   localparam logic [1:0] MODE_BYTE   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // configuration register indexes
   localparam logic CSR_DIGIT_MODE = 1'b0;
   localparam logic CSR_DP_ON      = 1'b1;

   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_DP    = 8'h80;

   // raw value with its magnitude and decimal quotients
   typedef struct packed {
      logic [15:0] raw;
      logic [16:0] mag;
      logic [11:0] q10;
      logic [8:0]  q100;
      logic [5:0]  q1000;
   } quot_type;

   function automatic logic [7:0] glyph(input logic [3:0] nib);
      logic [7:0] seg;
      case (nib)
         4'h0: seg = 8'h3F;
         4'h1: seg = 8'h06;
         4'h2: seg = 8'h5B;
         4'h3: seg = 8'h4F;
         4'h4: seg = 8'h66;
         4'h5: seg = 8'h6D;
         4'h6: seg = 8'h7D;
         4'h7: seg = 8'h07;
         4'h8: seg = 8'h7F;
         4'h9: seg = 8'h6F;
         4'hA: seg = 8'h77;
         4'hB: seg = 8'h7C;
         4'hC: seg = 8'h39;
         4'hD: seg = 8'h5E;
         4'hE: seg = 8'h79;
         4'hF: seg = 8'h71;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

/* hdl/ssns_bcd.sv */
// Magnitude and decimal quotient stage (value/10, /100, /1000) of the scanner.
// Depends on ssns_pkg (quot_type).
module ssns_bcd import ssns_pkg::*; (
   input  logic        clock,
   input  logic        load,
   input  logic [15:0] value,
   output quot_type    quot
);

   // reciprocal multiply: exact for magnitudes up to 32768
   localparam logic [33:0] RECIP10   = 34'd52429;  // >> 19
   localparam logic [33:0] RECIP100  = 34'd5243;   // >> 19
   localparam logic [33:0] RECIP1000 = 34'd67109;  // >> 26

   logic [16:0] mag;
   logic [33:0] p10, p100, p1000;
   quot_type    quot_in, quot_ff;

   assign mag = value[15] ? (17'h10000 - {1'b0, value}) : {1'b0, value};

   assign p10   = 34'(mag) * RECIP10;
   assign p100  = 34'(mag) * RECIP100;
   assign p1000 = 34'(mag) * RECIP1000;

   always_comb begin
      quot_in.raw   = value;
      quot_in.mag   = mag;
      quot_in.q10   = p10[30:19];
      quot_in.q100  = p100[27:19];
      quot_in.q1000 = p1000[31:26];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

/* hdl/seven_segment_number_scanner_unit.sv */
// Top level of the four-digit multiplexed seven-segment scanner.
// Depends on ssns_pkg and ssns_bcd.
//
// Usage: every request on req_ is one refresh tick carrying the signed 16-bit
// value to display. Each tick drives the digit at the current scan position
// (0,1,2,3,0,...), turns off the previously scanned digit and returns one
// response on rsp_ with the segment latch, the digit enable latch and the
// position handled. The display mode picks decimal with sign, four hex nibbles
// or two 7-bit bytes, and the unused code holds both latches; decimal_points_on
// lights the point on digits. The user must write both through csr_ while no
// request is in flight; the block itself does not enforce this. Each request
// passes the input register, quotient register and latch/output register.
// Throughput: one request per cycle; the three register stages are each
// parted by a valid bit, so a new request enters while a response waits.
// When rsp_tready is low, the response holds and the stages behind it fill;
// req_tready drops once all three are full.
// Reset: scan position 0, all digits off, segments cleared, display mode
// decimal, decimal points off, no response pending.
module seven_segment_number_scanner_unit import ssns_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value_shown
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] segment_bits, [11:8] digit_enables,
                                    // [13:12] scanned_position, [15:14] zero
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata
);

   logic        v0_ff, v1_ff, v2_ff;
   logic        adv1, adv2;
   logic [15:0] val_ff;
   quot_type    quot;

   logic [1:0]  mode_ff;
   logic        dp_on_ff;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  out_pos_ff;
   logic [7:0]  seg_ff, seg_in;
   logic [3:0]  en_ff, en_in;

   logic [3:0]  dig [4];
   logic [3:0]  dec_dig [4];
   logic [16:0] rem3;
   logic [11:0] rem2;
   logic [8:0]  rem1;
   logic [5:0]  q1000;
   logic        dec_neg;
   logic [7:0]  dp;

   // ---------------- pipeline control ----------------
   assign adv2       = v1_ff && (!v2_ff || rsp_tready);
   assign adv1       = v0_ff && (!v1_ff || adv2);
   assign req_tready = !v0_ff || adv1;
   assign rsp_tvalid = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            v0_ff <= req_tvalid;
         end
         if (!v1_ff || adv2) begin
            v1_ff <= v0_ff;
         end
         if (!v2_ff || rsp_tready) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         val_ff <= req_tdata;
      end
   end

   ssns_bcd u_bcd (
      .clock (clock),
      .load  (adv1),
      .value (val_ff),
      .quot  (quot)
   );

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DEC;
         dp_on_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DIGIT_MODE: mode_ff  <= csr_wdata;
            CSR_DP_ON:      dp_on_ff <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   // ---------------- digit split ----------------
   assign q1000 = quot.q1000;
   assign rem3  = quot.mag - (17'({quot.q10, 3'b000}) + 17'({quot.q10, 1'b0}));
   assign rem2  = quot.q10 - (12'({quot.q100, 3'b000}) + 12'({quot.q100, 1'b0}));
   assign rem1  = quot.q100 - (9'({q1000, 3'b000}) + 9'({q1000, 1'b0}));

   always_comb begin
      // thousands digit: quotient is at most 32
      if (q1000 >= 6'd30) begin
         dec_dig[0] = 4'(q1000 - 6'd30);
      end else if (q1000 >= 6'd20) begin
         dec_dig[0] = 4'(q1000 - 6'd20);
      end else if (q1000 >= 6'd10) begin
         dec_dig[0] = 4'(q1000 - 6'd10);
      end else begin
         dec_dig[0] = q1000[3:0];
      end
      dec_dig[1] = rem1[3:0];
      dec_dig[2] = rem2[3:0];
      dec_dig[3] = rem3[3:0];
   end

   always_comb begin
      case (mode_ff)
         MODE_DEC: begin
            dig[0] = dec_dig[0];
            dig[1] = dec_dig[1];
            dig[2] = dec_dig[2];
            dig[3] = dec_dig[3];
         end
         MODE_HEX: begin
            dig[0] = quot.raw[15:12];
            dig[1] = quot.raw[11:8];
            dig[2] = quot.raw[7:4];
            dig[3] = quot.raw[3:0];
         end
         default: begin
            dig[0] = {1'b0, quot.raw[13:11]};
            dig[1] = quot.raw[10:7];
            dig[2] = {1'b0, quot.raw[6:4]};
            dig[3] = quot.raw[3:0];
         end
      endcase
   end

   assign dec_neg = (mode_ff == MODE_DEC) && quot.raw[15];
   assign dp      = dp_on_ff ? SEG_DP : 8'h00;

   // ---------------- scan latch update ----------------
   always_comb begin
      seg_in = seg_ff;
      en_in  = en_ff;
      pos_in = pos_ff + 2'd1;
      if (mode_ff == MODE_DEC || mode_ff == MODE_HEX || mode_ff == MODE_BYTE) begin
         case (pos_ff)
            2'd0: begin
               en_in[3] = 1'b0;
               if (dec_neg) begin
                  // minus leads when the hundreds digit is nonzero
                  if (dig[1] != 4'd0) begin
                     seg_in   = SEG_MINUS;
                     en_in[0] = 1'b1;
                  end
                  seg_in = seg_in | dp;
               end else begin
                  seg_in   = glyph(dig[0]) | dp;
                  en_in[0] = (dig[0] != 4'd0);
               end
            end
            2'd1: begin
               en_in[0] = 1'b0;
               seg_in   = glyph(dig[1]) | dp;
               en_in[1] = (dig[0] != 4'd0) || (dig[1] != 4'd0);
               if (dec_neg && dig[2] != 4'd0 && dig[1] == 4'd0) begin
                  seg_in   = SEG_MINUS;
                  en_in[1] = 1'b1;
               end
            end
            2'd2: begin
               en_in[1] = 1'b0;
               seg_in   = glyph(dig[2]) | dp;
               en_in[2] = (dig[0] != 4'd0) || (dig[1] != 4'd0) || (dig[2] != 4'd0);
               if (dec_neg && dig[3] != 4'd0 && dig[2] == 4'd0) begin
                  seg_in   = SEG_MINUS;
                  en_in[2] = 1'b1;
               end
            end
            default: begin
               en_in[2] = 1'b0;
               seg_in   = glyph(dig[3]) | dp;
               en_in[3] = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         seg_ff <= 8'h00;
         en_ff  <= 4'h0;
      end else if (adv2) begin
         pos_ff <= pos_in;
         seg_ff <= seg_in;
         en_ff  <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         out_pos_ff <= pos_ff;
      end
   end

   assign rsp_tdata = {2'b00, out_pos_ff, en_ff, seg_ff};

   // ---------------- assertions ----------------
   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      adv2 |=> pos_ff == $past(pos_ff) + 2'd1)
      else $error("scan position did not advance on tick");

   a_rsp_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_pos_ff + 2'd1 == pos_ff)
      else $error("response position out of step with scan position");

   a_last_digit_on: assert property (@(posedge clock) disable iff (reset)
      (adv2 && pos_ff == 2'd3 && mode_ff != MODE_UNUSED) |=> en_ff[3])
      else $error("rightmost digit not enabled after its tick");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !adv2) |=> v1_ff && $stable(quot))
      else $error("quotient stage lost its request while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && en_ff == 4'h0 && pos_ff == 2'd0)
      else $error("state not cleared by reset");

endmodule

/* dv/ssns_scan_checker.sv */
`timescale 1ns / 100ps
// Checker for the seven-segment scanner: watches the csr, request and response
// channels, predicts each response and compares it. Depends on ssns_pkg.
module ssns_scan_checker import ssns_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata,
   output int          outstanding,
   output int          checked,
   output int          errors
);

   // a..g, dp glyphs for 0-9, A, b, C, d, E, F; digit 0 in the low byte
   localparam logic [127:0] SEGMENT_ROM = {
      8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
      8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] lit;
      logic [1:0] position;
   } scan_result_type;

   scan_result_type expected_scans[$];

   logic [1:0] mode_reg;
   logic       dp_reg;
   logic [1:0] scan_pos;
   logic [3:0] lit_latch;
   logic [7:0] seg_latch;
   int         accepted;

   assign outstanding = accepted - checked;

   function automatic logic [7:0] segments_for(input logic [3:0] d);
      return SEGMENT_ROM[int'(d) * 8 +: 8];
   endfunction

   // one refresh tick: update the display latches and queue the response
   task automatic scan_tick(input logic [15:0] value);
      logic            dec_neg;
      logic [7:0]      point;
      logic [3:0]      dig [4];
      int              mag;
      scan_result_type res;
      dec_neg = (mode_reg == MODE_DEC) && value[15];
      point   = dp_reg ? SEG_DP : 8'h00;
      mag     = value[15] ? 65536 - int'(value) : int'(value);
      if (mode_reg == MODE_DEC) begin
         dig[0] = 4'((mag / 1000) % 10);
         dig[1] = 4'((mag / 100) % 10);
         dig[2] = 4'((mag / 10) % 10);
         dig[3] = 4'(mag % 10);
      end else if (mode_reg == MODE_HEX) begin
         dig[0] = value[15:12];
         dig[1] = value[11:8];
         dig[2] = value[7:4];
         dig[3] = value[3:0];
      end else begin
         // bytes: hi = value[13:7], lo = value[6:0]
         dig[0] = {1'b0, value[13:11]};
         dig[1] = value[10:7];
         dig[2] = {1'b0, value[6:4]};
         dig[3] = value[3:0];
      end
      if (mode_reg == MODE_DEC || mode_reg == MODE_HEX || mode_reg == MODE_BYTE) begin
         case (scan_pos)
            2'd0: begin
               lit_latch[3] = 1'b0;
               if (dec_neg) begin
                  // leftmost digit only carries a minus; otherwise it keeps its state
                  if (dig[1] != 0) begin
                     seg_latch    = SEG_MINUS;
                     lit_latch[0] = 1'b1;
                  end
                  seg_latch = seg_latch | point;
               end else begin
                  seg_latch    = segments_for(dig[0]) | point;
                  lit_latch[0] = (dig[0] != 0);
               end
            end
            2'd1: begin
               lit_latch[0] = 1'b0;
               seg_latch    = segments_for(dig[1]) | point;
               lit_latch[1] = (dig[0] != 0) || (dig[1] != 0);
               if (dec_neg && dig[2] != 0 && dig[1] == 0) begin
                  seg_latch    = SEG_MINUS;
                  lit_latch[1] = 1'b1;
               end
            end
            2'd2: begin
               lit_latch[1] = 1'b0;
               seg_latch    = segments_for(dig[2]) | point;
               lit_latch[2] = (dig[0] != 0) || (dig[1] != 0) || (dig[2] != 0);
               if (dec_neg && dig[3] != 0 && dig[2] == 0) begin
                  seg_latch    = SEG_MINUS;
                  lit_latch[2] = 1'b1;
               end
            end
            default: begin
               lit_latch[2] = 1'b0;
               seg_latch    = segments_for(dig[3]) | point;
               lit_latch[3] = 1'b1;
            end
         endcase
      end
      res.segments = seg_latch;
      res.lit      = lit_latch;
      res.position = scan_pos;
      expected_scans.push_back(res);
      scan_pos = scan_pos + 2'd1;
   endtask

   always @(posedge clock) begin : monitor
      scan_result_type want;
      int              mismatches;
      mismatches = 0;
      if (reset) begin
         expected_scans.delete();
         mode_reg  = MODE_DEC;
         dp_reg    = 1'b0;
         scan_pos  = 2'd0;
         lit_latch = 4'h0;
         seg_latch = 8'h00;
         accepted <= 0;
         checked  <= 0;
         errors   <= 0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_DIGIT_MODE)
               mode_reg = csr_wdata;
            else
               dp_reg = csr_wdata[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            checked <= checked + 1;
            if (expected_scans.size() == 0) begin
               $error("response %h with no request pending", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_scans.pop_front();
               if (rsp_tdata[7:0] !== want.segments) begin
                  $error("segment_bits: expected %h, got %h", want.segments, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[11:8] !== want.lit) begin
                  $error("digit_enables: expected %h, got %h", want.lit, rsp_tdata[11:8]);
                  mismatches++;
               end
               if (rsp_tdata[13:12] !== want.position) begin
                  $error("scanned_position: expected %0d, got %0d",
                         want.position, rsp_tdata[13:12]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            accepted <= accepted + 1;
            scan_tick(req_tdata);
         end
         errors <= errors + mismatches;
      end
   end

endmodule

/* dv/tb_seven_segment_number_scanner_unit.sv */
`timescale 1ns / 100ps
// Testbench top for seven_segment_number_scanner_unit: drives csr writes and
// refresh-tick requests with random stalls. Depends on ssns_pkg and ssns_scan_checker.
module tb_seven_segment_number_scanner_unit import ssns_pkg::*; ();

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic        csr_index  = CSR_DIGIT_MODE;
   logic [1:0]  csr_wdata  = MODE_DEC;
   logic        steady     = 1'b0;
   int          outstanding;
   int          checked;
   int          errors;

   always #5 clock = ~clock;

   seven_segment_number_scanner_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ssns_scan_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .checked     (checked),
      .errors      (errors)
   );

   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 9);

   // one refresh tick; tvalid stays high after acceptance
   task automatic push_tick(input logic [15:0] value);
      while (!steady && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // drain everything in flight, then write both registers
   task automatic configure(input logic [1:0] mode, input logic dp);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_DIGIT_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      csr_index <= CSR_DP_ON;
      csr_wdata <= {1'b0, dp};
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [15:0] v;
      logic [1:0]  mode;
      int          mag;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, hidden leading digit, floating minus, blanking
      configure(MODE_DEC, 1'b0);
      push_tick(16'h0000);
      push_tick(16'h7FFF);
      push_tick(16'h8000);
      push_tick(16'hFFFF);
      repeat (4) push_tick(-16'sd105);
      repeat (4) push_tick(-16'sd1050);
      configure(MODE_HEX, 1'b1);
      repeat (4) push_tick(16'h00A0);
      configure(MODE_BYTE, 1'b0);
      repeat (4) push_tick(16'hFFFF);
      // unused mode holds both latches while the position advances
      configure(MODE_UNUSED, 1'b1);
      repeat (4) push_tick(16'h1234);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0, 1, 7: mode = MODE_DEC;
            2, 3:    mode = MODE_HEX;
            4, 5:    mode = MODE_BYTE;
            default: mode = MODE_UNUSED;
         endcase
         configure(mode, ph[0]);
         steady <= (ph == 4);
         for (int n = 0; n < ((ph == 6) ? 40 : 240); n++) begin
            mag = -1;
            case ($urandom_range(9))
               0, 1, 2: v = 16'($urandom);
               3, 4:    mag = $urandom_range(10 ** $urandom_range(1, 4) - 1);
               5, 6: begin
                  // decimal digits with zeros in random places
                  mag = 0;
                  repeat (4) mag = mag * 10 + ($urandom_range(1) ? $urandom_range(9) : 0);
               end
               7: begin
                  for (int k = 0; k < 4; k++)
                     v[4*k +: 4] = $urandom_range(1) ? 4'($urandom) : 4'h0;
               end
               8: begin
                  case ($urandom_range(5))
                     0:       v = 16'h0000;
                     1:       v = 16'hFFFF;
                     2:       v = 16'h7FFF;
                     3:       v = 16'h8000;
                     4:       v = 16'h8001;
                     default: v = 16'h0001;
                  endcase
               end
               default: mag = $urandom_range(10000, 32768);
            endcase
            if (mag >= 0)
               v = $urandom_range(1) ? 16'(-mag) : 16'(mag);
            push_tick(v);
         end
      end

      steady     <= 1'b0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      $display("Checked %0d scan ticks in decimal, hex, byte and unused modes,", checked);
      $display("decimal points off and on, with leading-zero blanking and minus placement.");
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout waiting for responses");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
